@@ rtl/core/bscd_pkg.sv @@
// Package with shared constants, types and codes of the byte stream codeword detector.
package bscd_pkg;

    localparam int CODEBOOK_DEPTH = 64;
    localparam int ADDR_W         = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;
    localparam int CNT_W          = $clog2(CODEBOOK_DEPTH + 1);

    localparam int WORD_W         = 16;
    localparam int BYTE_W         = 8;
    localparam int BUF_W          = 32;
    localparam int PREFIX_W       = 4;
    localparam int INDEX_W        = 6;
    localparam int COUNT_W        = 7;
    localparam int SEARCH_TOP     = 7;
    localparam int TARGET_TOP     = 16;
    localparam int SEARCH_N       = SEARCH_TOP + 1;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [PREFIX_W-1:0] PREFIX_RESET = 4'b1110;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIX      = 2'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    typedef struct packed {
        logic              is_data;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] value;
        logic [BYTE_W-1:0] data_byte;
        logic [WORD_W-1:0] target;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]    limit;
        logic [PREFIX_W-1:0] prefix;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

@@ rtl/core/bscd_in_if.sv @@
// Input channel interface carrying load and data beats.
interface bscd_in_if;
    import bscd_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [INDEX_W-1:0]   entry_index;
    logic [WORD_W-1:0]    entry_value;
    logic [BYTE_W-1:0]    data_byte;
    logic [WORD_W-1:0]    target_word;

    modport source (output valid, op, entry_index, entry_value, data_byte, target_word,
                    input ready);
    modport sink   (input valid, op, entry_index, entry_value, data_byte, target_word,
                    output ready);
endinterface

@@ rtl/core/bscd_out_if.sv @@
// Result channel interface carrying one beat per data item.
interface bscd_out_if;
    import bscd_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [WORD_W-1:0] found_word;
    logic              target_seen;

    modport source (output valid, found, found_word, target_seen, input ready);
    modport sink   (input valid, found, found_word, target_seen, output ready);
endinterface

@@ rtl/core/bscd_cfg_if.sv @@
// Configuration write channel interface.
interface bscd_cfg_if;
    import bscd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/byte_stream_codeword_detector.sv @@
// Top level of the byte stream codeword detector with its configuration registers.
// A load beat passes the front register and the queue; the idle back stage writes it and stays idle.
// A data beat's result is registered after a scan of min(entry_count, 64) codebook entries.
// The back stage reads one entry a cycle in its scan and pops no command until the result is loaded.
// Two queued commands and the front register let input beats arrive while a result waits.
// Synchronous active-low reset clears the shift buffer, queue and entry_count, sets prefix to 14.
module byte_stream_codeword_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bscd_in_if.sink    i_in,
    bscd_cfg_if.sink   i_cfg,
    bscd_out_if.source o_out
);
    import bscd_pkg::*;

    logic [COUNT_W-1:0]  r_entry_count;
    logic [PREFIX_W-1:0] r_prefix;
    t_cfg                cfg;
    logic                front_valid;
    t_cmd                front_cmd;
    logic                q_push_ready;
    logic                q_valid;
    t_cmd                q_cmd;
    logic                q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_prefix      <= PREFIX_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ENTRY_COUNT: r_entry_count <= i_cfg.data[COUNT_W-1:0];
                REG_PREFIX:      r_prefix      <= i_cfg.data[PREFIX_W-1:0];
                default:         r_prefix      <= r_prefix;
            endcase
        end
    end

    always_comb begin
        if (32'(r_entry_count) > 32'(CODEBOOK_DEPTH)) begin
            cfg.limit = CNT_W'(CODEBOOK_DEPTH);
        end else begin
            cfg.limit = CNT_W'(r_entry_count);
        end
        cfg.prefix = r_prefix;
    end

    bscd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (q_push_ready)
    );

    bscd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (front_valid),
        .i_data       (front_cmd),
        .o_push_ready (q_push_ready),
        .o_valid      (q_valid),
        .o_data       (q_cmd),
        .i_pop        (q_pop)
    );

    bscd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_cfg       (cfg),
        .o_out       (o_out)
    );
endmodule

@@ rtl/core/bscd_ram.sv @@
// Generic single write port RAM with registered read.
module bscd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/bscd_front.sv @@
// Front stage that accepts input beats, drops unusable loads and registers commands.
module bscd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bscd_in_if.sink         i_in,
    output logic            o_cmd_valid,
    output bscd_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_ready
);
    import bscd_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    logic accept;
    logic keep;

    assign i_in.ready = !r_valid || i_cmd_ready;
    assign accept     = i_in.valid && i_in.ready;
    assign keep       = (i_in.op == OP_DATA) ||
                        (32'(i_in.entry_index) < 32'(CODEBOOK_DEPTH));

    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        if (accept && keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && keep) begin
            r_cmd.is_data   <= (i_in.op == OP_DATA);
            r_cmd.addr      <= ADDR_W'(i_in.entry_index);
            r_cmd.value     <= i_in.entry_value;
            r_cmd.data_byte <= i_in.data_byte;
            r_cmd.target    <= i_in.target_word;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;
endmodule

@@ rtl/core/bscd_queue.sv @@
// Two entry command queue between the front and back stages.
module bscd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bscd_pkg::t_cmd  i_data,
    output logic            o_push_ready,
    output logic            o_valid,
    output bscd_pkg::t_cmd  o_data,
    input  logic            i_pop
);
    import bscd_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_valid      = (r_count != 2'd0);
    assign o_data       = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end
endmodule

@@ rtl/core/bscd_back.sv @@
// Back stage that writes the codebook, shifts the buffer, scans entries and drives results.
module bscd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  bscd_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    input  bscd_pkg::t_cfg  i_cfg,
    bscd_out_if.source      o_out
);
    import bscd_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [BUF_W-1:0]    r_buf;
    logic [WORD_W-1:0]   r_target;
    logic [SEARCH_N-1:0] r_hits;
    logic [CNT_W-1:0]    r_idx;
    logic                r_rd_v;
    logic                r_out_valid;
    logic                r_out_found;
    logic [WORD_W-1:0]   r_out_word;
    logic                r_out_seen;

    logic                pop;
    logic                ram_we;
    logic                ram_re;
    logic                out_load;
    logic [WORD_W-1:0]   rdata;
    logic [SEARCH_N-1:0] match;
    logic                sel_found;
    logic [WORD_W-1:0]   sel_word;
    logic                seen;

    bscd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CODEBOOK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.value),
        .i_re    (ram_re),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.is_data) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!ram_re && !r_rd_v) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        pop      = 1'b0;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                pop    = i_cmd_valid;
                ram_we = i_cmd_valid && !i_cmd.is_data;
            end
            ST_SCAN: begin
                ram_re = (r_idx < i_cfg.limit);
            end
            ST_FIN: begin
                out_load = !r_out_valid || o_out.ready;
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int o = 0; o < SEARCH_N; o++) begin
            match[o] = (r_buf[o + WORD_W - PREFIX_W +: PREFIX_W] == i_cfg.prefix) &&
                       (r_buf[o +: WORD_W] == rdata);
        end
        sel_found = 1'b0;
        sel_word  = '0;
        for (int o = 0; o < SEARCH_N; o++) begin
            if (r_hits[o]) begin
                sel_found = 1'b1;
                sel_word  = r_buf[o +: WORD_W];
            end
        end
        seen = 1'b0;
        for (int o = 0; o <= TARGET_TOP; o++) begin
            if (r_buf[o +: WORD_W] == r_target) begin
                seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_buf       <= '0;
            r_rd_v      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd_v  <= ram_re;
            if (pop && i_cmd.is_data) begin
                r_buf <= {r_buf[BUF_W-BYTE_W-1:0], i_cmd.data_byte};
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.is_data) begin
            r_target <= i_cmd.target;
            r_hits   <= '0;
            r_idx    <= '0;
        end else begin
            if (ram_re) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_rd_v) begin
                r_hits <= r_hits | match;
            end
        end
        if (out_load) begin
            r_out_found <= sel_found;
            r_out_word  <= sel_word;
            r_out_seen  <= seen;
        end
    end

    assign o_cmd_pop         = pop;
    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_out_found;
    assign o_out.found_word  = r_out_word;
    assign o_out.target_seen = r_out_seen;
endmodule
